// File: rtl/midi_file_event_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// MIDI file event parser assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MIDI_FILE_EVENT_PARSER_UNIT_MACROS_SVH
`define MIDI_FILE_EVENT_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MFEP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define MFEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define MFEP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MFEP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/mfep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI file event parser package
// Parse phases, result codes, status constants and the result record.
// ----------------------------------------------------------------------------
package mfep_pkg;

	// longest variable-length quantity accepted, in bytes
	localparam int unsigned MAX_LENGTH_BYTES = 4;
	// an event needs at least this many bytes left to start
	localparam logic [31:0] MIN_EVENT_BYTES = 32'd3;

	// status bytes
	localparam logic [7:0] ST_META       = 8'hFF;
	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
	localparam logic [7:0] ST_SYSTEM_MIN = 8'hF0;
	localparam logic [7:0] ST_STATUS_MIN = 8'h80;

	// channel message kinds with a single data byte
	localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
	localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DATA1    = 3'd1,
		PH_DATA2    = 3'd2,
		PH_METATYPE = 3'd3,
		PH_LEN      = 3'd4,
		PH_PARAMS   = 3'd5,
		PH_HALT     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PARAM  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_SHORT     = 2'd0,
		ERR_UNDEF     = 2'd1,
		ERR_BAD_LEN   = 2'd2,
		ERR_LEN_RANGE = 2'd3
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [27:0] param_length;
		logic [7:0]  param_byte;
		logic        last;
		err_t        error_code;
	} result_t;

	// channel messages other than program change and channel pressure take two data bytes
	function automatic logic three_byte(input logic [7:0] st);
		return !((st[7:4] == HI_PROG_CHANGE) || (st[7:4] == HI_CHAN_PRESS));
	endfunction

endpackage

// File: rtl/midi_file_event_parser_unit.sv
// A byte accepted into the input register gives its result in the result register when the input register advances.
// Throughput: one track byte per cycle; the input register holds only while the result is stalled.
// Each byte gives zero or one result; the phase register updates when the byte leaves the input register.
// Reset (arst_n low) clears all parse state and both valid flags; payload registers keep values.
// A write of track_length clears the parse state, loads the byte count and leaves the halted state.
// ----------------------------------------------------------------------------
// MIDI file event parser unit
// Splits MIDI track bytes into channel, meta and sysex events with running status.
// ----------------------------------------------------------------------------
`include "midi_file_event_parser_unit_macros.svh"

module midi_file_event_parser_unit
	import mfep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        track_length_we,
	input  logic [31:0] track_length,
	// byte request
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	// result request
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  status_byte,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic [27:0] param_length,
	output logic [7:0]  param_byte,
	output logic        last,
	output logic [1:0]  error_code
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// parse state
	phase_t      phase_q,        phase_n;
	logic [7:0]  running_q,      running_n;
	logic [31:0] bytes_left_q,   bytes_left_n;
	logic [7:0]  event_status_q, event_status_n;
	logic [7:0]  held_q,         held_n;
	logic [27:0] acc_q,          acc_n;
	logic [2:0]  seen_q,         seen_n;
	logic [27:0] params_left_q,  params_left_n;

	// result register
	logic        out_valid_q;
	result_t     res_q;
	result_t     res_n;
	logic        res_load;

	logic        advance;
	logic        err_hit;
	err_t        err_code;
	logic [31:0] bl_dec;
	logic [27:0] acc_cat;
	logic [2:0]  seen_inc;
	logic [27:0] params_dec;

	// handshake: input register moves on when the result slot is free or being taken
	assign advance    = valid_s1 & (~out_valid_q | ~result_stall);
	assign data_stall = valid_s1 & out_valid_q & result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// shared arithmetic on the current state
	assign bl_dec     = (bytes_left_q != 32'd0) ? bytes_left_q - 32'd1 : 32'd0;
	assign acc_cat    = {acc_q[20:0], byte_s1[6:0]};
	assign seen_inc   = seen_q + 3'd1;
	assign params_dec = (params_left_q != 28'd0) ? params_left_q - 28'd1 : 28'd0;

	// next state and result for the byte in the input register
	always_comb begin
		phase_n        = phase_q;
		running_n      = running_q;
		bytes_left_n   = bytes_left_q;
		event_status_n = event_status_q;
		held_n         = held_q;
		acc_n          = acc_q;
		seen_n         = seen_q;
		params_left_n  = params_left_q;
		res_load       = 1'b0;
		res_n          = '0;
		err_hit        = 1'b0;
		err_code       = ERR_SHORT;

		if (advance) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (bytes_left_q < MIN_EVENT_BYTES) begin
						err_hit  = 1'b1;
						err_code = ERR_SHORT;
					end else begin
						bytes_left_n = bl_dec;
						if (byte_s1 < ST_STATUS_MIN) begin
							// running status reuse
							if (running_q == 8'd0) begin
								err_hit  = 1'b1;
								err_code = ERR_UNDEF;
							end else begin
								event_status_n = running_q;
								held_n         = byte_s1;
								if (three_byte(running_q)) begin
									phase_n = PH_DATA2;
								end else begin
									res_load          = 1'b1;
									res_n.kind        = KIND_HEADER;
									res_n.status_byte = running_q;
									res_n.first_data  = byte_s1;
									res_n.last        = 1'b1;
								end
							end
						end else if (byte_s1 < ST_SYSTEM_MIN) begin
							running_n      = byte_s1;
							event_status_n = byte_s1;
							phase_n        = PH_DATA1;
						end else begin
							running_n = 8'd0;
							if (byte_s1 == ST_META) begin
								event_status_n = byte_s1;
								phase_n        = PH_METATYPE;
							end else if (byte_s1 == ST_SYSEX || byte_s1 == ST_SYSEX_ESC) begin
								event_status_n = byte_s1;
								held_n         = 8'd0;
								acc_n          = 28'd0;
								seen_n         = 3'd0;
								phase_n        = PH_LEN;
							end else begin
								err_hit  = 1'b1;
								err_code = ERR_UNDEF;
							end
						end
					end
				end
				PH_DATA1: begin
					bytes_left_n = bl_dec;
					held_n       = byte_s1;
					if (three_byte(event_status_q)) begin
						phase_n = PH_DATA2;
					end else begin
						phase_n           = PH_IDLE;
						res_load          = 1'b1;
						res_n.kind        = KIND_HEADER;
						res_n.status_byte = event_status_q;
						res_n.first_data  = byte_s1;
						res_n.last        = 1'b1;
					end
				end
				PH_DATA2: begin
					bytes_left_n      = bl_dec;
					phase_n           = PH_IDLE;
					res_load          = 1'b1;
					res_n.kind        = KIND_HEADER;
					res_n.status_byte = event_status_q;
					res_n.first_data  = held_q;
					res_n.second_data = byte_s1;
					res_n.last        = 1'b1;
				end
				PH_METATYPE: begin
					bytes_left_n = bl_dec;
					held_n       = byte_s1;
					acc_n        = 28'd0;
					seen_n       = 3'd0;
					phase_n      = PH_LEN;
				end
				PH_LEN: begin
					// one byte of the variable-length quantity
					bytes_left_n = bl_dec;
					acc_n        = acc_cat;
					seen_n       = seen_inc;
					if (byte_s1[7]) begin
						if (seen_inc >= 3'(MAX_LENGTH_BYTES) || bl_dec == 32'd0) begin
							err_hit  = 1'b1;
							err_code = ERR_BAD_LEN;
						end
					end else if ({4'd0, acc_cat} > bl_dec) begin
						err_hit  = 1'b1;
						err_code = ERR_LEN_RANGE;
					end else begin
						params_left_n      = acc_cat;
						phase_n            = (acc_cat != 28'd0) ? PH_PARAMS : PH_IDLE;
						res_load           = 1'b1;
						res_n.kind         = KIND_HEADER;
						res_n.status_byte  = event_status_q;
						res_n.first_data   = held_q;
						res_n.param_length = acc_cat;
						res_n.last         = (acc_cat == 28'd0);
					end
				end
				PH_PARAMS: begin
					bytes_left_n  = bl_dec;
					params_left_n = params_dec;
					if (params_dec == 28'd0) begin
						phase_n = PH_IDLE;
					end
					res_load           = 1'b1;
					res_n.kind         = KIND_PARAM;
					res_n.status_byte  = event_status_q;
					res_n.first_data   = held_q;
					res_n.param_length = acc_q;
					res_n.param_byte   = byte_s1;
					res_n.last         = (params_dec == 28'd0);
				end
				PH_HALT: begin
					// bytes are dropped until the next configuration write
				end
				default: begin
					phase_n = PH_HALT;
				end
			endcase

			// error result overrides and halts
			if (err_hit) begin
				phase_n          = PH_HALT;
				res_load         = 1'b1;
				res_n            = '0;
				res_n.kind       = KIND_ERROR;
				res_n.last       = 1'b1;
				res_n.error_code = err_code;
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			running_q      <= 8'd0;
			bytes_left_q   <= 32'd0;
			event_status_q <= 8'd0;
			held_q         <= 8'd0;
			acc_q          <= 28'd0;
			seen_q         <= 3'd0;
			params_left_q  <= 28'd0;
		end else if (track_length_we) begin
			phase_q        <= PH_IDLE;
			running_q      <= 8'd0;
			bytes_left_q   <= track_length;
			event_status_q <= 8'd0;
			held_q         <= 8'd0;
			acc_q          <= 28'd0;
			seen_q         <= 3'd0;
			params_left_q  <= 28'd0;
		end else begin
			phase_q        <= phase_n;
			running_q      <= running_n;
			bytes_left_q   <= bytes_left_n;
			event_status_q <= event_status_n;
			held_q         <= held_n;
			acc_q          <= acc_n;
			seen_q         <= seen_n;
			params_left_q  <= params_left_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_n;
		end
	end

	assign result_valid = out_valid_q;
	assign result_kind  = res_q.kind;
	assign status_byte  = res_q.status_byte;
	assign first_data   = res_q.first_data;
	assign second_data  = res_q.second_data;
	assign param_length = res_q.param_length;
	assign param_byte   = res_q.param_byte;
	assign last         = res_q.last;
	assign error_code   = res_q.error_code;

	// checks
	`MFEP_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, data_stall, out_valid_q && result_stall)
	`MFEP_ASSERT_IMPL(a_params_nonzero, clk, arst_n, phase_q == PH_PARAMS, params_left_q != 28'd0)
	`MFEP_ASSERT_IMPL(a_err_is_last, clk, arst_n, out_valid_q && res_q.kind == KIND_ERROR, res_q.last)
	`MFEP_ASSERT_NEXT(a_err_halts, clk, arst_n, advance && err_hit && !track_length_we, phase_q == PH_HALT)
	`MFEP_ASSERT_NEXT(a_halt_silent, clk, arst_n, phase_q == PH_HALT && !track_length_we, !$rose(out_valid_q))

endmodule
